>>> design/mnps_pkg.sv
// ----------------------------------------------------------------------------
// mnps_pkg: shared constants and tables for the mono note priority stack
// Stack sizing, field widths, opcode codes and the pitch and gain lookup
// tables. The tables are built once at elaboration.
// ----------------------------------------------------------------------------
package mnps_pkg;

    // stack sizing
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int PITCH_W = 18;
    localparam int GAIN_W  = 16;
    localparam int HELD_W  = 5;

    // opcodes
    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    // 440 Hz in 1/16 Hz units
    localparam logic [PITCH_W-1:0] RESET_PITCH = 18'd7040;

    // 10^(1/63) in Q30
    localparam longint unsigned MUL_Q30 = 64'd1113711966;

    // notes 108..119 in Hz times 8192
    localparam logic [31:0] PT [12] = '{
        32'd34291786, 32'd36330882, 32'd38491228, 32'd40780036,
        32'd43204943, 32'd45774044, 32'd48495909, 32'd51379626,
        32'd54434817, 32'd57671680, 32'd61101017, 32'd64734272
    };

    typedef logic [PITCH_W-1:0] t_pitch_tab [128];
    typedef logic [GAIN_W-1:0]  t_gain_tab  [128];

    // pitch per note: octave shift of the top octave with rounding
    function automatic t_pitch_tab build_pitch_tab();
        t_pitch_tab      tab;
        int              n;
        int              sh;
        longint unsigned v;
        for (int o = 0; o < 11; o++) begin
            for (int s = 0; s < 12; s++) begin
                n = o * 12 + s;
                if (n < 128) begin
                    sh     = 18 - o;
                    v      = 64'(PT[s]);
                    v      = (v + (64'd1 << (sh - 1))) >> sh;
                    tab[n] = PITCH_W'(v);
                end
            end
        end
        return tab;
    endfunction

    // gain per velocity: 327.68 * 10^((v-1)/63) rounded, in unsigned Q1.15
    function automatic t_gain_tab build_gain_tab();
        t_gain_tab       tab;
        int              v;
        longint unsigned a;
        longint unsigned p10;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        den    = 64'd25 << 30;
        tab[0] = '0;
        for (int d = 0; d < 3; d++) begin
            a   = 64'd1 << 30;
            p10 = (d == 0) ? 64'd1 : ((d == 1) ? 64'd10 : 64'd100);
            for (int j = 0; j < 63; j++) begin
                v = d * 63 + j + 1;
                if (j > 0) begin
                    a = (a * MUL_Q30 + (64'd1 << 29)) >> 30;
                end
                if (v < 128) begin
                    // rounded quotient by restoring long division
                    num = a * 64'd8192 * p10 + (64'd25 << 29);
                    q   = '0;
                    for (int b = 16; b >= 0; b--) begin
                        if (num >= (den << b)) begin
                            num = num - (den << b);
                            q   = q | (64'd1 << b);
                        end
                    end
                    tab[v] = GAIN_W'(q);
                end
            end
        end
        return tab;
    endfunction

    localparam t_pitch_tab PITCH_TAB = build_pitch_tab();
    localparam t_gain_tab  GAIN_TAB  = build_gain_tab();

endpackage

>>> design/mnps_ram.sv
// ----------------------------------------------------------------------------
// mnps_ram: generic single write, single read memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module mnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mono_note_priority_stack.sv
// ----------------------------------------------------------------------------
// mono_note_priority_stack: last-note priority stack for note events
// Note-on pushes a note and sets pitch and gain if the stack is not full;
// note-off or velocity zero removes every copy of the note by a compacting
// walk over the stack memory.
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------
//   in      | input     | i_in_valid / o_in_stall    | opcode note velocity
//   out     | output    | o_out_valid / i_out_stall  | trigger release_res
//           |           |                            | pitch gain held
//
// A note-on, or a note-off on an empty stack, goes from accept straight
// to the emit state. A note-off with notes held first walks the stack:
// the walk reads one stack entry per cycle through the single read port
// of the stack memory and compares it, then goes to the emit state.
// Reset is synchronous, active low, and empties the stack.
// o_in_stall is high while a transaction is in work; a stalled result
// sits in the output register and the next transaction may still enter.
// ----------------------------------------------------------------------------
module mono_note_priority_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [mnps_pkg::NOTE_W-1:0]   i_note,
    input  logic [mnps_pkg::VEL_W-1:0]    i_velocity,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_trigger,
    output logic                          o_release_res,
    output logic [mnps_pkg::PITCH_W-1:0]  o_pitch,
    output logic [mnps_pkg::GAIN_W-1:0]   o_gain,
    output logic [mnps_pkg::HELD_W-1:0]   o_held
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state                         r_state;
    logic [mnps_pkg::CNT_W-1:0]     r_count;
    logic [mnps_pkg::PITCH_W-1:0]   r_pitch;
    logic [mnps_pkg::GAIN_W-1:0]    r_gain;
    logic                           r_trig;
    logic                           r_rel;
    logic [mnps_pkg::NOTE_W-1:0]    r_op_note;
    logic [mnps_pkg::CNT_W-1:0]     r_rd_idx;
    logic [mnps_pkg::CNT_W-1:0]     r_wr_idx;
    logic                           r_pend;
    logic                           r_pend_last;
    logic [mnps_pkg::NOTE_W-1:0]    r_top_note;
    logic                           r_out_valid;
    logic                           r_o_trigger;
    logic                           r_o_release;
    logic [mnps_pkg::PITCH_W-1:0]   r_o_pitch;
    logic [mnps_pkg::GAIN_W-1:0]    r_o_gain;
    logic [mnps_pkg::HELD_W-1:0]    r_o_held;

    logic                           in_acc;
    logic                           is_off;
    logic                           not_full;
    logic                           rd_en;
    logic                           keep;
    logic [mnps_pkg::CNT_W-1:0]     n_wr_idx;
    logic                           ram_we;
    logic [mnps_pkg::IDX_W-1:0]     ram_waddr;
    logic [mnps_pkg::NOTE_W-1:0]    ram_wdata;
    logic [mnps_pkg::NOTE_W-1:0]    ram_q;

    // input handshake and decode
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign is_off   = (i_opcode == mnps_pkg::OP_NOTE_OFF) || (i_velocity == '0);
    assign not_full = r_count < mnps_pkg::CNT_W'(mnps_pkg::DEPTH);

    // walk: one read per cycle, compare against the removed note
    assign rd_en    = (r_state == S_WALK) && (r_rd_idx < r_count);
    assign keep     = r_pend && (ram_q != r_op_note);
    assign n_wr_idx = r_wr_idx + mnps_pkg::CNT_W'(keep);

    // stack memory write: push on note-on when not full, compaction in walk
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[mnps_pkg::IDX_W-1:0];
        ram_wdata = i_note;
        if (r_state == S_WALK) begin
            ram_we    = keep;
            ram_waddr = r_wr_idx[mnps_pkg::IDX_W-1:0];
            ram_wdata = ram_q;
        end else if (in_acc && !is_off && not_full) begin
            ram_we = 1'b1;
        end
    end

    mnps_ram #(
        .WIDTH (mnps_pkg::NOTE_W),
        .DEPTH (mnps_pkg::DEPTH),
        .ADDR_W(mnps_pkg::IDX_W)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (rd_en),
        .i_raddr(r_rd_idx[mnps_pkg::IDX_W-1:0]),
        .o_rdata(ram_q)
    );

    // sequencer, voice state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pitch     <= mnps_pkg::RESET_PITCH;
            r_gain      <= '0;
            r_trig      <= 1'b0;
            r_rel       <= 1'b0;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output transaction taken; a waiting result reloads it in emit
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op_note <= i_note;
                        r_trig    <= 1'b0;
                        r_rel     <= 1'b0;
                        r_rd_idx  <= '0;
                        r_wr_idx  <= '0;
                        r_pend    <= 1'b0;
                        if (!is_off) begin
                            if (not_full) begin
                                r_count <= r_count + mnps_pkg::CNT_W'(1);
                                r_pitch <= mnps_pkg::PITCH_TAB[i_note];
                                r_gain  <= mnps_pkg::GAIN_TAB[i_velocity];
                                r_trig  <= (r_count == '0);
                            end
                            r_state <= S_EMIT;
                        end else if (r_count == '0) begin
                            r_rel   <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + mnps_pkg::CNT_W'(1);
                    end
                    r_pend      <= rd_en;
                    r_pend_last <= rd_en && (r_rd_idx == r_count - mnps_pkg::CNT_W'(1));
                    if (keep) begin
                        r_wr_idx   <= n_wr_idx;
                        r_top_note <= ram_q;
                    end
                    // last entry seen: settle count, release and pitch
                    if (r_pend && r_pend_last) begin
                        r_count <= n_wr_idx;
                        r_rel   <= (n_wr_idx == '0);
                        if ((n_wr_idx != '0) && (ram_q == r_op_note)) begin
                            r_pitch <= mnps_pkg::PITCH_TAB[r_top_note];
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_trigger <= r_trig;
                        r_o_release <= r_rel;
                        r_o_pitch   <= r_pitch;
                        r_o_gain    <= r_gain;
                        r_o_held    <= mnps_pkg::HELD_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_trigger     = r_o_trigger;
    assign o_release_res = r_o_release;
    assign o_pitch       = r_o_pitch;
    assign o_gain        = r_o_gain;
    assign o_held        = r_o_held;

    // stack never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mnps_pkg::CNT_W'(mnps_pkg::DEPTH))
        else $error("stack count above depth");

    // compaction write never overtakes the read
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wr_idx <= r_rd_idx))
        else $error("compaction write ahead of read");

    // an accepted transaction closes the input until its result is out
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input open right after accept");

    // trigger and release never come together
    a_trig_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_trigger && o_release_res))
        else $error("trigger and release in one result");

    // release only with an empty stack
    a_rel_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_release_res) |-> (o_held == '0))
        else $error("release with notes held");

endmodule

>>> tb/mono_note_priority_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_note_priority_stack_tb: self-checking bench for the note priority stack
// Drives note-on and note-off transactions, first from a short table of
// corner cases and then at random in phases of varying idle pressure. A
// behavioral copy of the stack predicts the results the table leaves open,
// which are compared field by field with the transactions leaving the block.
// ----------------------------------------------------------------------------
module mono_note_priority_stack_tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 325;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 27;

    // one result transaction
    typedef struct packed {
        logic                         trig;
        logic                         rel;
        logic [mnps_pkg::PITCH_W-1:0] pitch;
        logic [mnps_pkg::GAIN_W-1:0]  gain;
        logic [mnps_pkg::HELD_W-1:0]  held;
    } t_note_result;

    // one stimulus row, optionally with a hand-written result
    typedef struct packed {
        logic                        op;
        logic [mnps_pkg::NOTE_W-1:0] note;
        logic [mnps_pkg::VEL_W-1:0]  vel;
        logic                        typed;
        t_note_result                res;
    } t_stim_row;

    // top octave (notes 108..119) in Hz scaled by 8192
    localparam logic [31:0] TOP_OCTAVE_Q13 [12] = '{
        32'd34291786, 32'd36330882, 32'd38491228, 32'd40780036,
        32'd43204943, 32'd45774044, 32'd48495909, 32'd51379626,
        32'd54434817, 32'd57671680, 32'd61101017, 32'd64734272
    };
    // one step of 10^(1/63) in Q30
    localparam longint unsigned DB_STEP_Q30 = 64'd1113711966;

    localparam t_note_result NO_RES = '0;

    // directed corner cases; typed rows carry results readable at a glance
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // note-off on the empty stack right after reset
        '{mnps_pkg::OP_NOTE_OFF, 7'd60,  7'd0,   1'b1,
          '{1'b0, 1'b1, 18'd7040, 16'd0, 5'd0}},
        // a4 at full velocity starts the envelopes
        '{mnps_pkg::OP_NOTE_ON,  7'd69,  7'd127, 1'b1,
          '{1'b1, 1'b0, 18'd7040, 16'd32768, 5'd1}},
        // lowest note at lowest velocity, -40 dB
        '{mnps_pkg::OP_NOTE_ON,  7'd0,   7'd1,   1'b1,
          '{1'b0, 1'b0, 18'd131, 16'd328, 5'd2}},
        '{mnps_pkg::OP_NOTE_ON,  7'd127, 7'd64,  1'b0, NO_RES},
        // same note held twice
        '{mnps_pkg::OP_NOTE_ON,  7'd0,   7'd100, 1'b0, NO_RES},
        // velocity zero releases a note below the top
        '{mnps_pkg::OP_NOTE_ON,  7'd69,  7'd0,   1'b0, NO_RES},
        // both copies go, top removed so the pitch follows the new top
        '{mnps_pkg::OP_NOTE_OFF, 7'd0,   7'd55,  1'b0, NO_RES},
        // note that is not held
        '{mnps_pkg::OP_NOTE_OFF, 7'd5,   7'd127, 1'b0, NO_RES},
        // last note off
        '{mnps_pkg::OP_NOTE_OFF, 7'd127, 7'd1,   1'b0, NO_RES},
        // fill the stack to its depth
        '{mnps_pkg::OP_NOTE_ON,  7'd64,  7'd127, 1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd12,  7'd1,   1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd127, 7'd63,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd0,   7'd64,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd33,  7'd126, 1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd45,  7'd2,   1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd90,  7'd100, 1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd101, 7'd32,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd7,   7'd16,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd88,  7'd8,   1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd55,  7'd4,   1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd119, 7'd127, 1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd64,  7'd50,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd3,   7'd90,  1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd76,  7'd110, 1'b0, NO_RES},
        '{mnps_pkg::OP_NOTE_ON,  7'd111, 7'd77,  1'b0, NO_RES},
        // stack full, note-on ignored
        '{mnps_pkg::OP_NOTE_ON,  7'd50,  7'd99,  1'b0, NO_RES},
        // top removed from a full stack, longest walk
        '{mnps_pkg::OP_NOTE_OFF, 7'd111, 7'd0,   1'b0, NO_RES}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         opcode;
    logic [mnps_pkg::NOTE_W-1:0]  note;
    logic [mnps_pkg::VEL_W-1:0]   velocity;
    logic                         out_valid;
    logic                         out_stall;
    logic                         trigger;
    logic                         release_res;
    logic [mnps_pkg::PITCH_W-1:0] pitch;
    logic [mnps_pkg::GAIN_W-1:0]  gain;
    logic [mnps_pkg::HELD_W-1:0]  held;

    // behavioral copy of the stack
    logic [mnps_pkg::NOTE_W-1:0]  stack_notes [mnps_pkg::DEPTH];
    int                           held_cnt;
    logic [mnps_pkg::PITCH_W-1:0] cur_pitch;
    logic [mnps_pkg::GAIN_W-1:0]  cur_gain;

    t_note_result       pending_results [$];
    int                 mismatches;
    int                 in_gap_max;
    int                 out_gap_max;
    int                 hold_request;

    mono_note_priority_stack i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_note        (note),
        .i_velocity    (velocity),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_trigger     (trigger),
        .o_release_res (release_res),
        .o_pitch       (pitch),
        .o_gain        (gain),
        .o_held        (held)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit
    initial begin
        #(10_000_000);
        $display("** mono_note_priority_stack: FAILED **");
        $finish;
    end

    // pitch: top octave value shifted down by octave, rounded
    function automatic logic [mnps_pkg::PITCH_W-1:0] note_to_pitch(
        input logic [mnps_pkg::NOTE_W-1:0] nt);
        int              semi;
        int              shift;
        longint unsigned f;
        semi  = int'(nt) % 12;
        shift = 18 - int'(nt) / 12;
        f     = 64'(TOP_OCTAVE_Q13[semi]);
        return mnps_pkg::PITCH_W'((f + (64'd1 << (shift - 1))) >> shift);
    endfunction

    // gain: -40 dB at velocity 1 rising in steps of 40/126 dB, unsigned Q1.15
    function automatic logic [mnps_pkg::GAIN_W-1:0] velocity_to_gain(
        input logic [mnps_pkg::VEL_W-1:0] vel);
        int              steps;
        int              decades;
        longint unsigned acc;
        longint unsigned scale;
        longint unsigned num;
        longint unsigned den;
        steps   = int'(vel) - 1;
        decades = steps / 63;
        acc     = 64'd1 << 30;
        den     = 64'd25 << 30;
        for (int i = 0; i < steps % 63; i++) begin
            acc = (acc * DB_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        scale = (decades == 0) ? 64'd1 : ((decades == 1) ? 64'd10 : 64'd100);
        num   = acc * 64'd8192 * scale;
        return mnps_pkg::GAIN_W'((num + den / 2) / den);
    endfunction

    // apply one event to the stack copy and return the result it yields
    function automatic t_note_result apply_note_event(
        input logic                        op,
        input logic [mnps_pkg::NOTE_W-1:0] nt,
        input logic [mnps_pkg::VEL_W-1:0]  vel);
        t_note_result r;
        int           w;
        bit           top_hit;
        r = '0;
        if (op == mnps_pkg::OP_NOTE_ON && vel != '0) begin
            if (held_cnt < mnps_pkg::DEPTH) begin
                stack_notes[held_cnt] = nt;
                held_cnt++;
                cur_pitch = note_to_pitch(nt);
                cur_gain  = velocity_to_gain(vel);
                r.trig    = (held_cnt == 1);
            end
        end else begin
            top_hit = (held_cnt > 0) && (stack_notes[held_cnt - 1] == nt);
            w = 0;
            for (int i = 0; i < held_cnt; i++) begin
                if (stack_notes[i] != nt) begin
                    stack_notes[w] = stack_notes[i];
                    w++;
                end
            end
            held_cnt = w;
            if (held_cnt == 0) begin
                r.rel = 1'b1;
            end else if (top_hit) begin
                cur_pitch = note_to_pitch(stack_notes[held_cnt - 1]);
            end
        end
        r.pitch = cur_pitch;
        r.gain  = cur_gain;
        r.held  = mnps_pkg::HELD_W'(held_cnt);
        return r;
    endfunction

    // offer one transaction after a random gap, predict once accepted
    task automatic send_note_event(input t_stim_row row);
        int           gap;
        t_note_result predicted;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= row.op;
        note     <= row.note;
        velocity <= row.vel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_note_event(row.op, row.note, row.vel);
        pending_results.push_back(row.typed ? row.res : predicted);
    endtask

    // random event, mostly note-ons and note-offs of held notes
    task automatic send_random_event(input int on_pct);
        t_stim_row row;
        int        pick;
        row       = '0;
        pick      = $urandom_range(0, 99);
        row.op    = mnps_pkg::OP_NOTE_OFF;
        row.note  = 7'($urandom_range(0, 127));
        row.vel   = 7'($urandom_range(0, 127));
        if (pick < on_pct) begin
            // narrow band of notes so duplicates show up
            row.op  = mnps_pkg::OP_NOTE_ON;
            row.vel = 7'($urandom_range(1, 127));
            if ($urandom_range(0, 1) == 1)
                row.note = 7'(60 + $urandom_range(0, 7));
        end else if (pick < on_pct + 8) begin
            row.op  = mnps_pkg::OP_NOTE_ON;
            row.vel = '0;
            if (held_cnt > 0 && $urandom_range(0, 1) == 1)
                row.note = stack_notes[$urandom_range(0, held_cnt - 1)];
        end else if (pick < 92 && held_cnt > 0) begin
            row.note = stack_notes[$urandom_range(0, held_cnt - 1)];
        end
        send_note_event(row);
    endtask

    // receiver: random stall before each transaction, long hold on request
    initial begin
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                n            = hold_request;
                hold_request = 0;
            end else begin
                n = $urandom_range(0, out_gap_max);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk) begin
        t_note_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: trig=%0d rel=%0d pitch=%0d gain=%0d held=%0d",
                             trigger, release_res, pitch, gain, held);
            end else begin
                want = pending_results.pop_front();
                if (trigger !== want.trig || release_res !== want.rel ||
                    pitch !== want.pitch || gain !== want.gain || held !== want.held) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: exp trig=%0d rel=%0d pitch=%0d gain=%0d held=%0d",
                                 want.trig, want.rel, want.pitch, want.gain, want.held);
                        $display("          got trig=%0d rel=%0d pitch=%0d gain=%0d held=%0d",
                                 trigger, release_res, pitch, gain, held);
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        int cycles;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = mnps_pkg::OP_NOTE_ON;
        note         = '0;
        velocity     = '0;
        mismatches   = 0;
        hold_request = 0;
        in_gap_max   = 15;
        out_gap_max  = 15;
        held_cnt     = 0;
        cur_pitch    = mnps_pkg::RESET_PITCH;
        cur_gain     = '0;
        for (int i = 0; i < mnps_pkg::DEPTH; i++) stack_notes[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++) send_note_event(DIRECTED[i]);

        // random phases: mixed idling, none, long receiver hold, receiver idling only
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin in_gap_max = 15; out_gap_max = 15; end
                1: begin in_gap_max = 0;  out_gap_max = 0;  end
                2: begin in_gap_max = 3;  out_gap_max = 15; hold_request = LONG_HOLD; end
                default: begin in_gap_max = 0; out_gap_max = 15; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_event((p == 1) ? 70 : ((p == 3) ? 40 : 55));
        end
        in_valid <= 1'b0;

        // drain
        cycles = 0;
        while (pending_results.size() != 0 && cycles < 100_000) begin
            @(posedge clk);
            cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        if (mismatches == 0) begin
            $display("** mono_note_priority_stack: PASSED **");
        end else begin
            $display("** mono_note_priority_stack: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
design/mnps_pkg.sv
design/mnps_ram.sv
design/mono_note_priority_stack.sv
tb/mono_note_priority_stack_tb.sv
